// ----- sv/hfl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hfl_pkg;

    localparam int ADDR_BITS       = 32;
    localparam int SIZE_FIELD_BITS = 31;
    localparam int ALLOC_FLAG_BIT  = 31;

    localparam int HDR_W   = 32;
    localparam int OUT_W   = 32;
    localparam int CFG_W   = 32;
    localparam int PADDR_W = 3;

    // size bits above the header width read as zero
    localparam int SIZE_W  = (SIZE_FIELD_BITS < HDR_W) ? SIZE_FIELD_BITS : HDR_W;
    localparam bit FLAG_IN = (ALLOC_FLAG_BIT < HDR_W);
    localparam int FLAG_IX = FLAG_IN ? ALLOC_FLAG_BIT : 0;

    localparam int EXT_W = (ADDR_BITS > OUT_W) ? ADDR_BITS : OUT_W;
    localparam int END_W = EXT_W + 1;
    localparam int SUM_W = ((ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W) + 1;

    // register index is paddr[2]
    localparam logic REG_HEAP_BASE   = 1'b0;
    localparam logic REG_HEAP_LENGTH = 1'b1;

    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_HEADER = 1'b1;

    localparam int OUT_BITS  = 4 + 7 * OUT_W;
    localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [CFG_W-1:0] heap_base;
        logic [CFG_W-1:0] heap_length;
    } t_cfg;

    typedef struct packed {
        logic             block_is_free;
        logic             has_previous_free;
        logic [OUT_W-1:0] previous_free_address;
        logic [OUT_W-1:0] this_block_address;
        logic [OUT_W-1:0] next_scan_address;
        logic             scan_done;
        logic             scan_error;
        logic [OUT_W-1:0] first_free_address;
        logic [OUT_W-1:0] last_free_address;
        logic [OUT_W-1:0] largest_free_address;
        logic [OUT_W-1:0] free_byte_total;
    } t_result;

    function automatic logic [OUT_W-1:0] to_out(input logic [ADDR_BITS-1:0] a);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(a);
        return ext[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- sv/heap_free_list_rebuild_scan.sv -----
// path: an accepted input transaction is held in the input register, then its result
// is held in the result register
// throughput: one header per cycle while results are taken; the scan state updates in the same cycle as the result
// ready drops only while the result register is full and not being taken
// reset (synchronous, active low) empties both registers, idles the scan, zeroes the config
`timescale 1ns / 1ps
`default_nettype none

module heap_free_list_rebuild_scan (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // slave side
    input  wire                             i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  wire  [hfl_pkg::HDR_W-1:0]       i_s_axis_tdata,  // header_word
    input  wire                             i_s_axis_tuser,  // command
    // master side
    output logic                            o_m_axis_tvalid,
    input  wire                             i_m_axis_tready,
    // block_is_free, has_previous_free, previous_free_address, this_block_address,
    // next_scan_address, scan_done, scan_error, first_free_address,
    // last_free_address, largest_free_address, free_byte_total, zero fill
    output logic [hfl_pkg::OUT_TDATA-1:0]   o_m_axis_tdata,
    // configuration
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire  [hfl_pkg::PADDR_W-1:0]     paddr,
    input  wire  [hfl_pkg::CFG_W-1:0]       pwdata,
    output logic [hfl_pkg::CFG_W-1:0]       prdata,
    output logic                            pready
);
    import hfl_pkg::*;

    t_cfg       cfg;
    t_result    result;

    logic             r_in_vld;
    logic             r_in_cmd;
    logic [HDR_W-1:0] r_in_hdr;
    logic             r_out_vld;
    t_result          r_out;
    logic             out_load;
    logic             in_take;

    assign out_load        = ~r_out_vld | i_m_axis_tready;
    assign in_take         = r_in_vld & out_load;
    assign o_s_axis_tready = ~r_in_vld | out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_cmd <= i_s_axis_tuser;
            r_in_hdr <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_out <= result;
        end
    end

    hfl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    hfl_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (in_take),
        .i_command (r_in_cmd),
        .i_header  (r_in_hdr),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {
        (OUT_TDATA - OUT_BITS)'(0),
        r_out.free_byte_total,
        r_out.largest_free_address,
        r_out.last_free_address,
        r_out.first_free_address,
        r_out.scan_error,
        r_out.scan_done,
        r_out.next_scan_address,
        r_out.this_block_address,
        r_out.previous_free_address,
        r_out.has_previous_free,
        r_out.block_is_free
    };

endmodule

`default_nettype wire

// ----- sv/hfl_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hfl_cfg (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [hfl_pkg::PADDR_W-1:0]  paddr,
    input  wire  [hfl_pkg::CFG_W-1:0]    pwdata,
    output logic [hfl_pkg::CFG_W-1:0]    prdata,
    output logic                         pready,
    output hfl_pkg::t_cfg                o_cfg
);
    import hfl_pkg::*;

    logic [CFG_W-1:0] r_heap_base;
    logic [CFG_W-1:0] r_heap_length;
    logic             wr_en;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base   <= '0;
            r_heap_length <= '0;
        end else if (wr_en) begin
            case (reg_sel)
                REG_HEAP_BASE:   r_heap_base   <= pwdata;
                REG_HEAP_LENGTH: r_heap_length <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_HEAP_BASE:   prdata = r_heap_base;
            REG_HEAP_LENGTH: prdata = r_heap_length;
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.heap_base   = r_heap_base;
    assign o_cfg.heap_length = r_heap_length;

endmodule

`default_nettype wire

// ----- sv/hfl_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hfl_scan (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_fire,
    input  wire                       i_command,
    input  wire  [hfl_pkg::HDR_W-1:0] i_header,
    input  hfl_pkg::t_cfg             i_cfg,
    output hfl_pkg::t_result          o_result
);
    import hfl_pkg::*;

    logic [ADDR_BITS-1:0] r_scan_addr,  n_scan_addr;
    logic [ADDR_BITS-1:0] r_prev_free,  n_prev_free;
    logic [ADDR_BITS-1:0] r_first_free, n_first_free;
    logic [ADDR_BITS-1:0] r_large_addr, n_large_addr;
    logic [SIZE_W-1:0]    r_large_size, n_large_size;
    logic [OUT_W-1:0]     r_free_sum,   n_free_sum;
    logic                 r_active,     n_active;
    logic                 r_list_vld,   n_list_vld;
    logic                 r_err,        n_err;

    logic [SIZE_W-1:0]    size;
    logic                 allocated;
    logic [ADDR_BITS-1:0] base_a;
    logic [END_W-1:0]     region_top;
    logic [SUM_W-1:0]     sum;
    logic                 carry;
    logic [ADDR_BITS-1:0] adv_addr;
    logic                 done;
    logic                 zero_size;

    assign size       = i_header[SIZE_W-1:0];
    assign allocated  = FLAG_IN ? i_header[FLAG_IX] : 1'b0;
    assign zero_size  = (size == '0);
    assign base_a     = ADDR_BITS'(i_cfg.heap_base);
    assign region_top = END_W'(base_a) + END_W'(i_cfg.heap_length);
    assign sum        = SUM_W'(r_scan_addr) + SUM_W'(size);
    assign carry      = (sum[SUM_W-1:ADDR_BITS] != '0);
    assign adv_addr   = sum[ADDR_BITS-1:0];
    assign done       = zero_size | carry | (END_W'(adv_addr) >= region_top);

    always_comb begin
        n_scan_addr  = r_scan_addr;
        n_prev_free  = r_prev_free;
        n_first_free = r_first_free;
        n_large_addr = r_large_addr;
        n_large_size = r_large_size;
        n_free_sum   = r_free_sum;
        n_active     = r_active;
        n_list_vld   = r_list_vld;
        n_err        = r_err;

        o_result                       = '0;
        o_result.next_scan_address     = to_out(r_scan_addr);
        o_result.scan_done             = 1'b1;
        o_result.scan_error            = r_err;

        if (i_command == CMD_START) begin
            n_scan_addr  = base_a;
            n_prev_free  = '0;
            n_first_free = '0;
            n_large_addr = '0;
            n_large_size = '0;
            n_free_sum   = '0;
            n_list_vld   = 1'b0;
            n_err        = 1'b0;
            n_active     = (i_cfg.heap_length != '0);
            o_result.next_scan_address = to_out(base_a);
            o_result.scan_done         = ~n_active;
            o_result.scan_error        = 1'b0;
        end else if (r_active) begin
            o_result.this_block_address = to_out(r_scan_addr);
            if (!allocated) begin
                o_result.block_is_free = 1'b1;
                if (size > r_large_size) begin
                    n_large_size = size;
                    n_large_addr = r_scan_addr;
                end
                n_free_sum = r_free_sum + OUT_W'(size);
                if (r_list_vld) begin
                    o_result.has_previous_free     = 1'b1;
                    o_result.previous_free_address = to_out(r_prev_free);
                end else begin
                    n_first_free = r_scan_addr;
                    n_list_vld   = 1'b1;
                end
                n_prev_free = r_scan_addr;
            end
            // zero-size block stops in place with an error
            n_scan_addr = zero_size ? r_scan_addr : adv_addr;
            if (done) begin
                n_active = 1'b0;
                n_err    = zero_size;
            end
            o_result.next_scan_address = to_out(n_scan_addr);
            o_result.scan_done         = done;
            o_result.scan_error        = zero_size;
        end

        o_result.first_free_address   = n_list_vld ? to_out(n_first_free) : '0;
        o_result.last_free_address    = n_list_vld ? to_out(n_prev_free) : '0;
        o_result.largest_free_address = to_out(n_large_addr);
        o_result.free_byte_total      = n_free_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_addr  <= '0;
            r_prev_free  <= '0;
            r_first_free <= '0;
            r_large_addr <= '0;
            r_large_size <= '0;
            r_free_sum   <= '0;
            r_active     <= 1'b0;
            r_list_vld   <= 1'b0;
            r_err        <= 1'b0;
        end else if (i_fire) begin
            r_scan_addr  <= n_scan_addr;
            r_prev_free  <= n_prev_free;
            r_first_free <= n_first_free;
            r_large_addr <= n_large_addr;
            r_large_size <= n_large_size;
            r_free_sum   <= n_free_sum;
            r_active     <= n_active;
            r_list_vld   <= n_list_vld;
            r_err        <= n_err;
        end
    end

    a_err_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.scan_error |-> o_result.scan_done)
        else $error("scan error without scan done");

    a_prev_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.has_previous_free |-> (o_result.block_is_free && r_list_vld))
        else $error("back link on a block that is not free");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_command == CMD_HEADER && o_result.scan_done) |=> !r_active)
        else $error("scan still active after done");

    a_start_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_command == CMD_START) |=>
            (r_active == $past(i_cfg.heap_length != '0)) && !r_list_vld)
        else $error("start did not set up the scan");

    a_err_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> !r_active)
        else $error("error latched while scanning");

endmodule

`default_nettype wire

// ----- sim/heap_walk_checker.sv -----
`timescale 1ns / 1ps

module heap_walk_checker
    import hfl_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_s_tvalid,
    input  wire                  i_s_tready,
    input  wire  [HDR_W-1:0]     i_s_tdata,
    input  wire                  i_s_tuser,
    input  wire                  i_m_tvalid,
    input  wire                  i_m_tready,
    input  wire  [OUT_TDATA-1:0] i_m_tdata,
    input  wire                  i_psel,
    input  wire                  i_penable,
    input  wire                  i_pwrite,
    input  wire  [PADDR_W-1:0]   i_paddr,
    input  wire  [CFG_W-1:0]     i_pwdata,
    input  wire                  i_pready,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked,
    output int                   o_starts,
    output int                   o_zero_stops
);

    localparam logic [63:0] ADDR_MASK =
        (ADDR_BITS >= 64) ? '1 : ((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [63:0] SIZE_MASK =
        (SIZE_FIELD_BITS >= 64) ? '1 : ((64'd1 << SIZE_FIELD_BITS) - 64'd1);

    // register copies
    logic [CFG_W-1:0] heap_base_cfg;
    logic [CFG_W-1:0] heap_len_cfg;

    // scan state
    logic [63:0] walk_addr;
    logic [63:0] prev_free;
    logic [63:0] head_free;
    logic [63:0] big_addr;
    logic [63:0] big_size;
    logic [31:0] free_total;
    logic        walking;
    logic        list_ok;
    logic        err_latched;

    t_result walk_reports[$];

    int fails      = 0;
    int checked    = 0;
    int starts     = 0;
    int zero_stops = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_starts     = 0;
        o_zero_stops = 0;
    end

    function automatic void clear_scan();
        walk_addr   = '0;
        prev_free   = '0;
        head_free   = '0;
        big_addr    = '0;
        big_size    = '0;
        free_total  = '0;
        walking     = 1'b0;
        list_ok     = 1'b0;
        err_latched = 1'b0;
    endfunction

    // advances the scan by one command and returns the report it produces
    function automatic t_result walk_header(input logic cmd, input logic [HDR_W-1:0] hdr);
        t_result     r;
        logic [63:0] here;
        logic [63:0] blk_size;
        logic [63:0] step_to;
        logic [64:0] sum;
        logic [64:0] heap_top;
        logic        taken;
        logic        stopped;
        logic        bad;
        r = '0;
        if (cmd == CMD_START) begin
            clear_scan();
            walk_addr = 64'(heap_base_cfg) & ADDR_MASK;
            walking   = (heap_len_cfg != '0);
            r.next_scan_address = walk_addr[OUT_W-1:0];
            r.scan_done         = !walking;
            starts++;
        end else if (!walking) begin
            // header outside a scan reports done, the latched error and the totals, with no block
            r.next_scan_address = walk_addr[OUT_W-1:0];
            r.scan_done         = 1'b1;
            r.scan_error        = err_latched;
        end else begin
            here     = walk_addr;
            blk_size = 64'(hdr) & SIZE_MASK;
            taken    = ((64'(hdr) >> ALLOC_FLAG_BIT) & 64'd1) != 64'd0;
            bad      = 1'b0;
            if (!taken) begin
                r.block_is_free = 1'b1;
                if (blk_size > big_size) begin
                    big_size = blk_size;
                    big_addr = here;
                end
                free_total = free_total + blk_size[31:0];
                if (list_ok) begin
                    r.has_previous_free     = 1'b1;
                    r.previous_free_address = prev_free[OUT_W-1:0];
                end else begin
                    head_free = here;
                    list_ok   = 1'b1;
                end
                prev_free = here;
            end
            if (blk_size == '0) begin
                bad     = 1'b1;
                stopped = 1'b1;
                step_to = here;
            end else begin
                sum      = {1'b0, here} + {1'b0, blk_size};
                heap_top = {1'b0, 64'(heap_base_cfg) & ADDR_MASK} + 65'(heap_len_cfg);
                step_to  = sum[63:0] & ADDR_MASK;
                // a carry out of the address width counts as the heap end
                stopped  = (sum > {1'b0, ADDR_MASK}) || ({1'b0, step_to} >= heap_top);
            end
            walk_addr = step_to;
            if (stopped) begin
                walking     = 1'b0;
                err_latched = bad;
                if (bad) zero_stops++;
            end
            r.this_block_address = here[OUT_W-1:0];
            r.next_scan_address  = step_to[OUT_W-1:0];
            r.scan_done          = stopped;
            r.scan_error         = bad;
        end
        r.first_free_address   = list_ok ? head_free[OUT_W-1:0] : '0;
        r.last_free_address    = list_ok ? prev_free[OUT_W-1:0] : '0;
        r.largest_free_address = big_addr[OUT_W-1:0];
        r.free_byte_total      = free_total;
        return r;
    endfunction

    function automatic string field_note(input string name, input logic [63:0] e,
                                         input logic [63:0] g);
        return (e !== g) ? $sformatf(" %s exp=%0h got=%0h", name, e, g) : "";
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        string   diffs;
        if (!i_rst_n) begin
            heap_base_cfg = '0;
            heap_len_cfg  = '0;
            clear_scan();
            walk_reports.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_HEAP_BASE) heap_base_cfg = i_pwdata;
                else heap_len_cfg = i_pwdata;
            end
            if (i_m_tvalid && i_m_tready) begin
                got.block_is_free         = i_m_tdata[0];
                got.has_previous_free     = i_m_tdata[1];
                got.previous_free_address = i_m_tdata[2 +: OUT_W];
                got.this_block_address    = i_m_tdata[2 + OUT_W +: OUT_W];
                got.next_scan_address     = i_m_tdata[2 + 2 * OUT_W +: OUT_W];
                got.scan_done             = i_m_tdata[2 + 3 * OUT_W];
                got.scan_error            = i_m_tdata[3 + 3 * OUT_W];
                got.first_free_address    = i_m_tdata[4 + 3 * OUT_W +: OUT_W];
                got.last_free_address     = i_m_tdata[4 + 4 * OUT_W +: OUT_W];
                got.largest_free_address  = i_m_tdata[4 + 5 * OUT_W +: OUT_W];
                got.free_byte_total       = i_m_tdata[4 + 6 * OUT_W +: OUT_W];
                checked++;
                if (walk_reports.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("result transaction %0d arrived with nothing pending: %h",
                                 checked, i_m_tdata);
                end else begin
                    want  = walk_reports.pop_front();
                    diffs = {field_note("block_is_free", want.block_is_free,
                                        got.block_is_free),
                             field_note("has_previous_free", want.has_previous_free,
                                        got.has_previous_free),
                             field_note("previous_free_address", want.previous_free_address,
                                        got.previous_free_address),
                             field_note("this_block_address", want.this_block_address,
                                        got.this_block_address),
                             field_note("next_scan_address", want.next_scan_address,
                                        got.next_scan_address),
                             field_note("scan_done", want.scan_done, got.scan_done),
                             field_note("scan_error", want.scan_error, got.scan_error),
                             field_note("first_free_address", want.first_free_address,
                                        got.first_free_address),
                             field_note("last_free_address", want.last_free_address,
                                        got.last_free_address),
                             field_note("largest_free_address", want.largest_free_address,
                                        got.largest_free_address),
                             field_note("free_byte_total", want.free_byte_total,
                                        got.free_byte_total)};
                    if (diffs != "") begin
                        fails++;
                        if (fails <= 10)
                            $display("result transaction %0d mismatch:%s", checked, diffs);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                walk_reports.push_back(walk_header(i_s_tuser, i_s_tdata));
        end
        o_fail_count <= fails;
        o_pending    <= walk_reports.size();
        o_checked    <= checked;
        o_starts     <= starts;
        o_zero_stops <= zero_stops;
    end

endmodule

// ----- sim/tb_heap_free_list_rebuild_scan.sv -----
`timescale 1ns / 1ps

module tb_heap_free_list_rebuild_scan;
    import hfl_pkg::*;

    localparam int ITEM_TARGET  = 1650;
    localparam int CALM_TAIL    = 250;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [PADDR_W-1:0] BASE_ADDR = PADDR_W'({REG_HEAP_BASE, 2'b00});
    localparam logic [PADDR_W-1:0] LEN_ADDR  = PADDR_W'({REG_HEAP_LENGTH, 2'b00});

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 s_tvalid = 1'b0;
    logic [HDR_W-1:0]     s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    wire                  s_tready;
    wire                  m_tvalid;
    logic                 m_tready = 1'b0;
    wire [OUT_TDATA-1:0]  m_tdata;

    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [PADDR_W-1:0]   paddr   = '0;
    logic [CFG_W-1:0]     pwdata  = '0;
    wire  [CFG_W-1:0]     prdata;
    wire                  pready;

    int fail_count;
    int pending;
    int checked;
    int starts;
    int zero_stops;

    int sent_items   = 0;
    int settings     = 0;
    int gap_odds     = 0;
    int stall_odds   = 0;
    int stall_left   = 0;
    int quiet_cycles = 0;
    bit calm         = 1'b0;

    always #5 i_clk = ~i_clk;

    heap_free_list_rebuild_scan i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    heap_walk_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_starts     (starts),
        .o_zero_stops (zero_stops)
    );

    // result side stalls in bursts
    always @(posedge i_clk) begin
        if (stall_left > 0)
            stall_left = stall_left - 1;
        else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            stall_left = $urandom_range(1, 15);
        m_tready <= i_rst_n && (stall_left == 0);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("timeout: no transaction for %0d cycles, %0d results still pending",
                 STALL_LIMIT, pending);
        $display("[heap_free_list_rebuild_scan] ERROR");
        $finish;
    end

    task automatic send_item(input logic cmd, input logic [HDR_W-1:0] hdr);
        if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= hdr;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent_items++;
    endtask

    // block idle: wait until every result is taken, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_heap(input logic [CFG_W-1:0] base, input logic [CFG_W-1:0] len);
        apb_write(BASE_ADDR, base);
        apb_write(LEN_ADDR, len);
        settings++;
    endtask

    function automatic logic [HDR_W-1:0] header_of(input logic [31:0] blk_size,
                                                   input logic taken);
        return HDR_W'(blk_size) | (HDR_W'(taken) << ALLOC_FLAG_BIT);
    endfunction

    initial begin : stimulus
        logic [63:0] rem;
        logic [31:0] cap;
        logic [31:0] blk_size;
        logic [31:0] base;
        logic [31:0] len;
        int          blocks;
        int          pick;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // header with no scan open, then an empty heap
        send_item(CMD_HEADER, 32'h0000_0040);
        send_item(CMD_START, '0);
        send_item(CMD_HEADER, 32'hFFFF_FFFF);
        drain();

        // free, taken, equal-size free (first largest kept), free reaching the end
        set_heap(32'h0000_1000, 32'h0000_0100);
        send_item(CMD_START, 32'hFFFF_FFFF);
        send_item(CMD_HEADER, header_of(32'h40, 1'b0));
        send_item(CMD_HEADER, header_of(32'h40, 1'b1));
        send_item(CMD_HEADER, header_of(32'h40, 1'b0));
        send_item(CMD_HEADER, header_of(32'h40, 1'b0));
        send_item(CMD_HEADER, header_of(32'h40, 1'b0));
        // zero-size blocks stop the scan, free and taken
        send_item(CMD_START, '0);
        send_item(CMD_HEADER, header_of(32'h0, 1'b0));
        send_item(CMD_HEADER, header_of(32'h10, 1'b0));
        send_item(CMD_START, '0);
        send_item(CMD_HEADER, header_of(32'h0, 1'b1));
        drain();

        // advance carrying out of the address width
        set_heap(32'hFFFF_FFFF, 32'h0000_0001);
        send_item(CMD_START, '0);
        send_item(CMD_HEADER, header_of(32'h2, 1'b0));
        drain();

        // whole address space: free total wraps, then largest taken header
        set_heap(32'h0000_0000, 32'hFFFF_FFFF);
        send_item(CMD_START, '0);
        repeat (3) send_item(CMD_HEADER, header_of(32'h7FFF_FFFF, 1'b0));
        send_item(CMD_START, '0);
        send_item(CMD_HEADER, 32'hFFFF_FFFF);
        drain();

        set_heap(32'hFFFF_FFFF, 32'h0000_0000);
        send_item(CMD_START, '0);
        send_item(CMD_HEADER, header_of(32'h8, 1'b0));

        while (sent_items < ITEM_TARGET) begin
            drain();
            case ($urandom_range(0, 5))
                0:       base = '0;
                1:       base = 32'hFFFF_FFFF - $urandom_range(0, 4095);
                2, 3:    base = $urandom & ~32'h7;
                default: base = $urandom;
            endcase
            case ($urandom_range(0, 9))
                0:       len = '0;
                1:       len = 32'hFFFF_FFFF;
                2:       len = $urandom;
                default: len = $urandom_range(1, 4096);
            endcase
            set_heap(base, len);
            if ($urandom_range(0, 3) == 0) cap = $urandom_range(1, 16);
            else cap = len >> $urandom_range(2, 5);
            if (cap == 0) cap = 1;
            if (cap > 32'h7FFF_FFFF) cap = 32'h7FFF_FFFF;
            case ($urandom_range(0, 2))
                0:       gap_odds = 0;
                1:       gap_odds = 4;
                default: gap_odds = 12;
            endcase
            case ($urandom_range(0, 2))
                0:       stall_odds = 0;
                1:       stall_odds = 4;
                default: stall_odds = 12;
            endcase

            repeat ($urandom_range(3, 12)) begin
                if (sent_items >= ITEM_TARGET) break;
                calm = (sent_items >= ITEM_TARGET - CALM_TAIL);
                send_item(CMD_START, $urandom);
                rem    = 64'(len);
                blocks = 0;
                while (rem != 0 && blocks < 48) begin
                    blocks++;
                    pick = $urandom_range(0, 99);
                    if (pick < 3) begin
                        send_item(CMD_HEADER, header_of(32'h0, 1'($urandom_range(0, 1))));
                        break;
                    end else if (pick < 5) begin
                        break;  // abandon the scan mid-way
                    end else if (pick < 8) begin
                        send_item(CMD_HEADER, $urandom);
                        break;
                    end else begin
                        if (rem <= 64'(cap) && $urandom_range(0, 2) == 0)
                            blk_size = rem[31:0];
                        else
                            blk_size = $urandom_range(1, cap);
                        send_item(CMD_HEADER, header_of(blk_size, $urandom_range(0, 9) < 4));
                        rem = (64'(blk_size) >= rem) ? 64'd0 : rem - 64'(blk_size);
                    end
                end
                // random headers after the scan's last block; the scan may still be open
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 3)) send_item(CMD_HEADER, $urandom);
            end
        end
        drain();

        $display("%0d result transactions checked over %0d scans, %0d stopped on a zero-size block",
                 checked, starts, zero_stops);
        $display("%0d heap register settings, %0d mismatches", settings, fail_count);
        if (fail_count == 0)
            $display("[heap_free_list_rebuild_scan] OK");
        else
            $display("[heap_free_list_rebuild_scan] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/hfl_pkg.sv
sv/hfl_cfg.sv
sv/hfl_scan.sv
sv/heap_free_list_rebuild_scan.sv
sim/heap_walk_checker.sv
sim/tb_heap_free_list_rebuild_scan.sv
